// ----- rtl/mbfe_pkg.sv -----
// shared types and constants for the multiscale box feature extractor
// depends on nothing; used by the controller, the datapath and the top level
package mbfe_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 32;
  localparam int ROW_BITS = 4;
  localparam int COL_BITS = 5;
  localparam int FEAT_COUNT = GRID_ROWS + GRID_COLS;

  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_FRAME_LENGTH = 2'd1;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  channel;
    logic [8:0]  time_index;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  box_number;
    logic [5:0]  feat_idx;
    logic signed [23:0] feature;
    logic        last_of_box;
    logic        last_box;
    logic        no_box;
  } out_item_t;

  typedef struct packed {
    logic store;
    logic check;
    logic scan;
    logic emit_step;
    logic advance;
    logic nb_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic nobox;
    logic issue_last;
    logic emit_last;
  } ctrl_status_t;

endpackage

// ----- rtl/multiscale_box_feature_extractor_top.sv -----
// store command: written straight into the frame memory. compute command: 512*(height/16)*(width/32)
// frame memory reads (one read port, one sample a cycle), then 48 results one a cycle while out_stall is low
// no-box compute: one result with no_box set; one request at a time
// reset (rst, synchronous) restores registers and the first box; the frame memory
// is not cleared
module multiscale_box_feature_extractor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mbfe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  mbfe_pkg::ctrl_cmd_t    cmd;
  mbfe_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  mbfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(in_data.cmd),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .status(status)
  );

  mbfe_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .status(status),
    .out_item(out_data)
  );

`ifndef ASSERT_OFF
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while results pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_box_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last_of_box |=> !out_valid)
    else $error("result after last of box");
`endif

endmodule

// ----- rtl/mbfe_ctrl.sv -----
// sequencing state machine for store, scan and feature output
// depends on mbfe_pkg for the command and status structs
module mbfe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbfe_pkg::ctrl_cmd_t   cmd,
  input  mbfe_pkg::ctrl_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_NOBOX = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd == mbfe_pkg::CMD_STORE) begin
            cmd.store = 1'b1;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = status.nobox ? S_NOBOX : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            cmd.advance = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_NOBOX: begin
        out_valid = 1'b1;
        cmd.nb_sel = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mbfe_dp.sv -----
// frame memory, box enumeration, pixel accumulation and feature output
// depends on mbfe_pkg for payload, command and status types
module mbfe_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [9:0]             cfg_data,
  input  mbfe_pkg::in_item_t     in_item,
  input  mbfe_pkg::ctrl_cmd_t    cmd,
  output mbfe_pkg::ctrl_status_t status,
  output mbfe_pkg::out_item_t    out_item
);

  logic signed [15:0] frame_mem [65536];

  logic [7:0] cc_reg;
  logic [9:0] fl_reg;
  logic [7:0] height;
  logic [2:0] hsh;
  logic [7:0] top;
  logic [9:0] width;
  logic [2:0] wsh;
  logic [9:0] box_cnt;

  logic [7:0] eff_cc, half_cc;
  logic [9:0] eff_fl;
  logic       nobox, invalid;

  assign eff_cc = (cc_reg > 8'd128) ? 8'd128 : cc_reg;
  assign eff_fl = (fl_reg > 10'd512) ? 10'd512 : fl_reg;
  assign half_cc = {1'b0, eff_cc[7:1]};
  assign nobox = !((8'(mbfe_pkg::GRID_ROWS) < half_cc) && (10'(mbfe_pkg::GRID_COLS) < eff_fl));
  assign invalid = (width >= eff_fl) || (height < 8'(mbfe_pkg::GRID_ROWS)) ||
                   (height >= half_cc) || (top >= eff_cc) || (top < height);

  // next box of the enumeration
  logic [10:0] nw;
  logic [7:0]  nt, nh2;
  logic        wrap_w, wrap_h, last;
  assign nw = {width, 1'b0};
  assign wrap_w = nw >= {1'b0, eff_fl};
  assign nt = top - {1'b0, height[7:1]};
  assign wrap_h = nt < height;
  assign nh2 = {height[6:0], 1'b0};
  assign last = wrap_w && wrap_h && !(nh2 < half_cc);

  // scan counters
  localparam int ROW_BITS_L = mbfe_pkg::ROW_BITS;
  logic [ROW_BITS_L-1:0] pi;
  logic [mbfe_pkg::COL_BITS-1:0] pj;
  logic [7:0] pk;
  logic [8:0] pl;
  logic [7:0] pc_m1;
  logic [8:0] ps_m1;
  logic [7:0] row;
  logic [8:0] tcol;
  logic       pix_last, all_last;

  assign pc_m1 = 8'((9'd1 << hsh) - 9'd1);
  assign ps_m1 = 9'((10'd1 << wsh) - 10'd1);
  assign row = (top - height) + 8'({4'b0, pi} << hsh) + pk;
  assign tcol = 9'({4'b0, pj} << wsh) + pl;
  assign pix_last = (pl == ps_m1) && (pk == pc_m1);
  assign all_last = pix_last && (pj == mbfe_pkg::COL_BITS'(mbfe_pkg::GRID_COLS - 1)) &&
                    (pi == ROW_BITS_L'(mbfe_pkg::GRID_ROWS - 1));

  // read stage tags
  logic rd_v, rd_pix_last;
  logic [ROW_BITS_L-1:0] rd_i;
  logic [mbfe_pkg::COL_BITS-1:0] rd_j;
  logic signed [15:0] rdata;

  logic signed [25:0] acc, acc_sum;
  logic signed [33:0] scaled;
  logic signed [23:0] pixel;
  logic signed [27:0] colsum [mbfe_pkg::GRID_COLS];
  logic signed [28:0] rowsum, rowsum_sum;
  logic signed [23:0] rowmean [mbfe_pkg::GRID_ROWS];

  assign acc_sum = acc + 26'(rdata);
  assign scaled = (34'(acc_sum) <<< 8) >>> (hsh + wsh);
  assign pixel = 24'(scaled);
  assign rowsum_sum = rowsum + 29'(pixel);

  logic [5:0] ok;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      frame_mem[{in_item.channel, in_item.time_index}] <= in_item.sample;
    end
    rdata <= frame_mem[{row[6:0], tcol}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc_reg <= 8'd128;
      fl_reg <= 10'd512;
      height <= 8'(mbfe_pkg::GRID_ROWS);
      hsh <= 3'd0;
      top <= 8'd127;
      width <= 10'(mbfe_pkg::GRID_COLS);
      wsh <= 3'd0;
      box_cnt <= 10'd0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan;
      if (cfg_we && (cfg_index == mbfe_pkg::CFG_CHANNEL_COUNT ||
                     cfg_index == mbfe_pkg::CFG_FRAME_LENGTH)) begin
        if (cfg_index == mbfe_pkg::CFG_CHANNEL_COUNT) begin
          cc_reg <= cfg_data[7:0];
          top <= ((cfg_data[7:0] > 8'd128) ? 8'd128 :
                  (cfg_data[7:0] == 8'd0 ? 8'd1 : cfg_data[7:0])) - 8'd1;
        end else begin
          fl_reg <= cfg_data;
          top <= (eff_cc == 8'd0) ? 8'd0 : eff_cc - 8'd1;
        end
        height <= 8'(mbfe_pkg::GRID_ROWS);
        hsh <= 3'd0;
        width <= 10'(mbfe_pkg::GRID_COLS);
        wsh <= 3'd0;
        box_cnt <= 10'd0;
      end else if (cmd.check && !nobox && invalid) begin
        height <= 8'(mbfe_pkg::GRID_ROWS);
        hsh <= 3'd0;
        top <= eff_cc - 8'd1;
        width <= 10'(mbfe_pkg::GRID_COLS);
        wsh <= 3'd0;
        box_cnt <= 10'd0;
      end else if (cmd.advance) begin
        box_cnt <= last ? 10'd0 : box_cnt + 10'd1;
        if (wrap_w) begin
          width <= 10'(mbfe_pkg::GRID_COLS);
          wsh <= 3'd0;
          if (wrap_h) begin
            top <= eff_cc - 8'd1;
            if (last) begin
              height <= 8'(mbfe_pkg::GRID_ROWS);
              hsh <= 3'd0;
            end else begin
              height <= nh2;
              hsh <= hsh + 3'd1;
            end
          end else begin
            top <= nt;
          end
        end else begin
          width <= nw[9:0];
          wsh <= wsh + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pix_last <= pix_last;
    rd_i <= pi;
    rd_j <= pj;
    if (cmd.check) begin
      pi <= '0;
      pj <= '0;
      pk <= '0;
      pl <= '0;
      acc <= '0;
      rowsum <= '0;
      ok <= '0;
      for (int c = 0; c < mbfe_pkg::GRID_COLS; c++) begin
        colsum[c] <= '0;
      end
    end else begin
      if (cmd.scan) begin
        if (pl != ps_m1) begin
          pl <= pl + 9'd1;
        end else begin
          pl <= '0;
          if (pk != pc_m1) begin
            pk <= pk + 8'd1;
          end else begin
            pk <= '0;
            pj <= pj + mbfe_pkg::COL_BITS'(1);
            if (pj == mbfe_pkg::COL_BITS'(mbfe_pkg::GRID_COLS - 1)) begin
              pi <= pi + ROW_BITS_L'(1);
            end
          end
        end
      end
      if (rd_v) begin
        if (rd_pix_last) begin
          acc <= '0;
          colsum[rd_j] <= colsum[rd_j] + 28'(pixel);
          if (rd_j == mbfe_pkg::COL_BITS'(mbfe_pkg::GRID_COLS - 1)) begin
            rowmean[rd_i] <= 24'(rowsum_sum >>> 5);
            rowsum <= '0;
          end else begin
            rowsum <= rowsum_sum;
          end
        end else begin
          acc <= acc_sum;
        end
      end
      if (cmd.emit_step) begin
        ok <= ok + 6'd1;
      end
    end
  end

  logic signed [27:0] col_sel;
  assign col_sel = colsum[5'(ok - 6'(mbfe_pkg::GRID_ROWS))];

  always_comb begin
    out_item = '0;
    if (cmd.nb_sel) begin
      out_item.no_box = 1'b1;
    end else begin
      out_item.box_number = box_cnt;
      out_item.feat_idx = ok;
      out_item.feature = (ok < 6'(mbfe_pkg::GRID_ROWS)) ? rowmean[ok[3:0]] :
                         24'(col_sel >>> 4);
      out_item.last_of_box = (ok == 6'(mbfe_pkg::FEAT_COUNT - 1));
      out_item.last_box = last;
    end
  end

  assign status.nobox = nobox;
  assign status.issue_last = cmd.scan && all_last;
  assign status.emit_last = (ok == 6'(mbfe_pkg::FEAT_COUNT - 1));

endmodule

// ----- dv/mbfe_checker.sv -----
// checker for the multiscale box feature extractor: watches the config, request and result channels
// keeps its own frame copy and box enumeration and compares every result with its prediction
// depends on mbfe_pkg
module mbfe_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mbfe_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mbfe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [15:0] frame_copy [0:65535];
  logic [7:0] chan_reg;
  logic [9:0] len_reg;
  int box_h, box_t, box_w;
  logic [9:0] box_num;
  mbfe_pkg::out_item_t feature_q[$];

  function automatic int used_channels();
    return (chan_reg > 128) ? 128 : int'(chan_reg);
  endfunction

  function automatic int used_length();
    return (len_reg > 512) ? 512 : int'(len_reg);
  endfunction

  function automatic void rewind_boxes();
    int cc;
    cc = used_channels();
    box_h = mbfe_pkg::GRID_ROWS;
    box_t = (cc != 0) ? cc - 1 : 0;
    box_w = mbfe_pkg::GRID_COLS;
    box_num = '0;
  endfunction

  // averages the current box onto the grid and queues its 48 means, or one no_box result when no box fits
  function automatic void predict_box_means();
    int cc, fl, pc, ps, bot, shift, nw, nh, nt;
    longint acc;
    longint pix [mbfe_pkg::GRID_ROWS][mbfe_pkg::GRID_COLS];
    logic last;
    mbfe_pkg::out_item_t r;
    cc = used_channels();
    fl = used_length();
    r = '0;
    if (!(mbfe_pkg::GRID_ROWS < cc / 2 && mbfe_pkg::GRID_COLS < fl)) begin
      r.no_box = 1'b1;
      feature_q.insert(feature_q.size(), r);
      return;
    end
    if (box_w >= fl || box_h < mbfe_pkg::GRID_ROWS || box_h >= cc / 2 || box_t >= cc ||
        box_t < box_h)
      rewind_boxes();
    pc = box_h / mbfe_pkg::GRID_ROWS;
    ps = box_w / mbfe_pkg::GRID_COLS;
    shift = $clog2(pc * ps);
    bot = box_t - box_h;
    for (int i = 0; i < mbfe_pkg::GRID_ROWS; i++) begin
      for (int j = 0; j < mbfe_pkg::GRID_COLS; j++) begin
        acc = 0;
        for (int k = 0; k < pc; k++)
          for (int l = 0; l < ps; l++)
            acc += frame_copy[(bot + i * pc + k) * 512 + j * ps + l];
        pix[i][j] = (acc * 256) >>> shift;
      end
    end
    nw = box_w * 2;
    nh = box_h;
    nt = box_t;
    last = 1'b0;
    if (nw >= fl) begin
      nw = mbfe_pkg::GRID_COLS;
      nt -= box_h / 2;
      if (nt - nh < 0) begin
        nh *= 2;
        nt = cc - 1;
        if (!(nh < cc / 2)) begin
          last = 1'b1;
          nh = mbfe_pkg::GRID_ROWS;
        end
      end
    end
    for (int k = 0; k < mbfe_pkg::FEAT_COUNT; k++) begin
      acc = 0;
      if (k < mbfe_pkg::GRID_ROWS) begin
        for (int j = 0; j < mbfe_pkg::GRID_COLS; j++) acc += pix[k][j];
        acc = acc >>> mbfe_pkg::COL_BITS;
      end else begin
        for (int i = 0; i < mbfe_pkg::GRID_ROWS; i++) acc += pix[i][k - mbfe_pkg::GRID_ROWS];
        acc = acc >>> mbfe_pkg::ROW_BITS;
      end
      r.box_number = box_num;
      r.feat_idx = k[5:0];
      r.feature = acc[23:0];
      r.last_of_box = (k == mbfe_pkg::FEAT_COUNT - 1);
      r.last_box = last;
      r.no_box = 1'b0;
      feature_q.insert(feature_q.size(), r);
    end
    box_w = nw;
    box_h = nh;
    box_t = nt;
    box_num = last ? '0 : box_num + 10'd1;
  endfunction

  always @(posedge clk) begin
    mbfe_pkg::out_item_t want;
    if (rst) begin
      chan_reg = 8'd128;
      len_reg = 10'd512;
      rewind_boxes();
      feature_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mbfe_pkg::CFG_CHANNEL_COUNT: begin
            chan_reg = cfg_data[7:0];
            rewind_boxes();
          end
          mbfe_pkg::CFG_FRAME_LENGTH: begin
            len_reg = cfg_data;
            rewind_boxes();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == mbfe_pkg::CMD_STORE)
          frame_copy[{in_data.channel, in_data.time_index}] = in_data.sample;
        else
          predict_box_means();
      end
      if (out_valid && !out_stall) begin
        if (feature_q.size() == 0) begin
          $error("unexpected result: box_number %0d feat_idx %0d",
                 out_data.box_number, out_data.feat_idx);
          errors++;
        end else begin
          want = feature_q.pop_front();
          if (out_data.box_number !== want.box_number) begin
            $error("box_number: expected %0d, got %0d", want.box_number, out_data.box_number);
            errors++;
          end
          if (out_data.feat_idx !== want.feat_idx) begin
            $error("feat_idx: expected %0d, got %0d", want.feat_idx,
                   out_data.feat_idx);
            errors++;
          end
          if (out_data.feature !== want.feature) begin
            $error("feature: expected %0d, got %0d", want.feature, out_data.feature);
            errors++;
          end
          if (out_data.last_of_box !== want.last_of_box) begin
            $error("last_of_box: expected %0b, got %0b", want.last_of_box,
                   out_data.last_of_box);
            errors++;
          end
          if (out_data.last_box !== want.last_box) begin
            $error("last_box: expected %0b, got %0b", want.last_box, out_data.last_box);
            errors++;
          end
          if (out_data.no_box !== want.no_box) begin
            $error("no_box: expected %0b, got %0b", want.no_box, out_data.no_box);
            errors++;
          end
        end
      end
    end
    pending = feature_q.size();
  end

endmodule

// ----- dv/multiscale_box_feature_extractor_top_tb.sv -----
// testbench top for the multiscale box feature extractor: clock, reset, requests,
// config writes, result stalls and the verdict; depends on mbfe_pkg and mbfe_checker
module multiscale_box_feature_extractor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mbfe_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mbfe_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = mbfe_pkg::CFG_CHANNEL_COUNT;
  logic [9:0] cfg_data = '0;
  int errors;
  int pending;
  logic quiet = 1'b0;
  int idle_cycles = 0;

  int phase_chans [6] = '{66, 34, 40, 255, 128, 66};
  int phase_lens [6] = '{33, 64, 40, 33, 65, 1023};

  multiscale_box_feature_extractor_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mbfe_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (rst || quiet) ? 1'b0 : ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mbfe_pkg::in_item_t make_request(logic cmd);
    mbfe_pkg::in_item_t it;
    it.cmd = cmd;
    it.channel = 7'($urandom);
    it.time_index = 9'($urandom);
    it.sample = pick_sample();
    return it;
  endfunction

  task automatic send_request(mbfe_pkg::in_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop the request and wait until every expected result is out and a store has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_computes(int n);
    repeat (n) send_request(make_request(mbfe_pkg::CMD_COMPUTE));
  endtask

  initial begin
    mbfe_pkg::in_item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // load the whole frame so that no box can read an unwritten sample
    for (int ch = 0; ch < 128; ch++) begin
      quiet = (ch >= 100);
      for (int t = 0; t < 512; t++) begin
        it = make_request(mbfe_pkg::CMD_STORE);
        it.channel = ch[6:0];
        it.time_index = t[8:0];
        send_request(it);
      end
    end
    quiet = 1'b0;
    // default sizes: widths 32 up to 256 on the first top
    run_computes(4);
    write_reg(mbfe_pkg::CFG_CHANNEL_COUNT, 10'd0);
    run_computes(1);
    write_reg(mbfe_pkg::CFG_CHANNEL_COUNT, 10'd1);
    write_reg(mbfe_pkg::CFG_FRAME_LENGTH, 10'd1);
    run_computes(1);
    write_reg(2'd2, 10'h3ff);
    write_reg(2'd3, 10'h2aa);
    run_computes(1);
    // above the maxima both settings are clamped to 128 and 512
    write_reg(mbfe_pkg::CFG_CHANNEL_COUNT, 10'd255);
    write_reg(mbfe_pkg::CFG_FRAME_LENGTH, 10'd1023);
    run_computes(2);
    // three boxes, so the fourth compute wraps
    write_reg(mbfe_pkg::CFG_CHANNEL_COUNT, 10'd34);
    write_reg(mbfe_pkg::CFG_FRAME_LENGTH, 10'd33);
    run_computes(5);
    for (int p = 0; p < 6; p++) begin
      write_reg(mbfe_pkg::CFG_CHANNEL_COUNT, phase_chans[p][9:0]);
      write_reg(mbfe_pkg::CFG_FRAME_LENGTH, phase_lens[p][9:0]);
      quiet = (p == 2);
      for (int n = 0; n < 42; n++)
        send_request(make_request(($urandom_range(99) < 30) ? mbfe_pkg::CMD_COMPUTE :
                                                             mbfe_pkg::CMD_STORE));
      quiet = 1'b0;
    end
    drain();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
